// File: sv/scs_pkg.sv
// Shared types, widths and constants for the stick channel shaping block.
// No dependencies; every other file uses it through scoped names.
package scs_pkg;

    // Field and arithmetic widths.
    localparam int RAW_W      = 16;             // width of the raw sample field
    localparam int RAW_BITS   = 16;             // raw bits taken into account (8..16)
    localparam int QBITS      = 10;             // quotient bits of both dividers
    localparam int NUM_W      = RAW_BITS + QBITS; // normalize numerator width
    localparam int DZ_W       = 10;
    localparam int DZN_W      = 20;             // deadzone numerator width
    localparam int EXPO_W     = 7;
    localparam int OUT_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Scale constants.
    localparam int FULL_SCALE = 1000;
    localparam int PERCENT    = 100;

    // Reciprocals for division by constants: floor(n/C) is (n*R)>>S or one less.
    localparam int RECIP_1000 = 1049;
    localparam int SH_1000    = 20;
    localparam int RECIP_100  = 167773;
    localparam int SH_100     = 24;

    // Pipeline stage positions.
    localparam int ST_IN  = 0;
    localparam int ST_MUL = 1;
    localparam int ST_SAT = 2;              // first of QBITS+1 normalize divider stages
    localparam int ST_NRM = ST_SAT + QBITS + 1;
    localparam int ST_DZ  = ST_NRM + 1;     // first of QBITS+1 deadzone divider stages
    localparam int ST_X   = ST_DZ + QBITS + 1;
    localparam int ST_SQ  = ST_X + 1;
    localparam int ST_SQR = ST_SQ + 1;
    localparam int ST_SQC = ST_SQR + 1;
    localparam int ST_CU  = ST_SQC + 1;
    localparam int ST_CUR = ST_CU + 1;
    localparam int ST_CUC = ST_CUR + 1;
    localparam int ST_MIX = ST_CUC + 1;
    localparam int ST_SUM = ST_MIX + 1;
    localparam int ST_DVR = ST_SUM + 1;
    localparam int ST_OUT = ST_DVR + 1;
    localparam int N_STG  = ST_OUT + 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN    = 3'd0,
        CFG_CENTER = 3'd1,
        CFG_MAX    = 3'd2,
        CFG_DEAD   = 3'd3,
        CFG_EXPO   = 3'd4
    } t_cfg_idx;

    // Forced normalize result, decided before the division.
    typedef enum logic [1:0] {
        FRC_NONE = 2'd0,
        FRC_ZERO = 2'd1,
        FRC_NEG  = 2'd2
    } t_force;

    // One step of the normalize divider.
    typedef struct packed {
        logic [NUM_W-1:0]    rem;
        logic [RAW_BITS-1:0] span;
        logic [QBITS-1:0]    q;
        logic                sat;
        logic                lower;
        t_force              frc;
    } t_nd1;

    // One step of the deadzone divider.
    typedef struct packed {
        logic [DZN_W-1:0]        rem;
        logic [DZ_W-1:0]         den;
        logic [QBITS-1:0]        q;
        logic                    byp;
        logic                    inb;
        logic                    neg;
        logic signed [OUT_W-1:0] v;
    } t_nd2;

endpackage

// File: sv/scs_chan_if.sv
// Valid/ready channel interfaces for raw samples and shaped values.
// Depends on scs_pkg for the field widths.
interface scs_raw_if;
    logic                          valid;
    logic                          ready;
    logic [scs_pkg::RAW_W-1:0]     raw_sample;
    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface scs_shp_if;
    logic                             valid;
    logic                             ready;
    logic signed [scs_pkg::OUT_W-1:0] shaped_value;
    modport source (output valid, output shaped_value, input ready);
    modport sink   (input valid, input shaped_value, output ready);
endinterface

// File: sv/stick_channel_shaping.sv
// Stick channel shaping: calibration normalize, deadzone and cubic expo.
// Depends on scs_pkg and the channel interfaces in scs_chan_if.sv.
//
//   channel   dir  word          width
//   i_raw     in   raw_sample    16 unsigned
//   o_shp     out  shaped_value  11 signed
//   i_cfg_*   in   register write (index 3, data 16)
//
// One word enters per cycle while the pipeline is not stalled; a word passes
// 36 register stages before its result can leave.
// The length comes from the two restoring dividers, one quotient bit per stage,
// plus the multiply and correct stages of the expo curve.
// Every stage holds its own valid bit and moves on when the stage after it is
// empty or moving, so a stalled output only fills the pipeline behind it.
// Reset is synchronous, clears the valid bits and sets the configuration registers to their defaults.
module stick_channel_shaping (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    scs_raw_if.sink                             i_raw,
    scs_shp_if.source                           o_shp,
    input  logic                                i_cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [scs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int RB  = scs_pkg::RAW_BITS;
    localparam int NW  = scs_pkg::NUM_W;
    localparam int QB  = scs_pkg::QBITS;
    localparam int NS  = scs_pkg::N_STG;
    localparam int OW  = scs_pkg::OUT_W;
    localparam int DW  = scs_pkg::DZ_W;
    localparam int DNW = scs_pkg::DZN_W;

    // Configuration registers.
    logic [scs_pkg::RAW_W-1:0]  r_cfg_min, r_cfg_center, r_cfg_max;
    logic [DW-1:0]              r_cfg_dead;
    logic [scs_pkg::EXPO_W-1:0] r_cfg_expo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_min    <= '0;
            r_cfg_center <= 16'h8000;
            r_cfg_max    <= 16'hFFFF;
            r_cfg_dead   <= '0;
            r_cfg_expo   <= '0;
        end else if (i_cfg_we) begin
            case (scs_pkg::t_cfg_idx'(i_cfg_idx))
                scs_pkg::CFG_MIN:    r_cfg_min    <= i_cfg_data;
                scs_pkg::CFG_CENTER: r_cfg_center <= i_cfg_data;
                scs_pkg::CFG_MAX:    r_cfg_max    <= i_cfg_data;
                scs_pkg::CFG_DEAD:   r_cfg_dead   <= i_cfg_data[DW-1:0];
                scs_pkg::CFG_EXPO:   r_cfg_expo   <= i_cfg_data[scs_pkg::EXPO_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valid bits and per-stage advance chain.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS:0]   w_adv;

    assign w_adv[NS] = o_shp.ready;
    for (genvar gi = 0; gi < NS; gi++) begin : g_adv
        assign w_adv[gi] = !r_vld[gi] || w_adv[gi+1];
    end

    assign i_raw.ready = w_adv[scs_pkg::ST_IN];
    assign n_vld = {r_vld[NS-2:0], i_raw.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (w_adv[NS-1:0] & n_vld) | (~w_adv[NS-1:0] & r_vld);
        end
    end

    // Input capture.
    logic [scs_pkg::RAW_W-1:0] r_raw;

    always_ff @(posedge i_clk) begin
        if (w_adv[scs_pkg::ST_IN]) begin
            r_raw <= i_raw.raw_sample;
        end
    end

    // Pick the half, its span and the scaled numerator.
    logic [RB-1:0]    w_raw, w_mn, w_ct, w_mx, w_span, w_udiff;
    logic             w_lower;
    scs_pkg::t_force  w_frc;
    logic [NW-1:0]    r1_num;
    logic [RB-1:0]    r1_span;
    logic             r1_lower;
    scs_pkg::t_force  r1_frc;

    always_comb begin
        w_raw   = r_raw[RB-1:0];
        w_mn    = r_cfg_min[RB-1:0];
        w_ct    = r_cfg_center[RB-1:0];
        w_mx    = r_cfg_max[RB-1:0];
        w_lower = (w_raw <= w_ct);
        w_span  = w_lower ? (w_ct - w_mn) : (w_mx - w_ct);
        w_udiff = w_lower ? (w_raw - w_mn) : (w_raw - w_ct);
        if (w_mx == w_mn || w_span == '0) begin
            w_frc = scs_pkg::FRC_ZERO;
        end else if (w_lower && w_raw < w_mn) begin
            w_frc = scs_pkg::FRC_NEG;
        end else begin
            w_frc = scs_pkg::FRC_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[scs_pkg::ST_MUL]) begin
            r1_num   <= NW'(w_udiff) * NW'(scs_pkg::FULL_SCALE);
            r1_span  <= w_span;
            r1_lower <= w_lower;
            r1_frc   <= w_frc;
        end
    end

    // Normalize divider: saturation check, then one quotient bit per stage.
    scs_pkg::t_nd1 r_d1 [0:QB];

    always_ff @(posedge i_clk) begin
        if (w_adv[scs_pkg::ST_SAT]) begin
            r_d1[0].rem   <= r1_num;
            r_d1[0].span  <= r1_span;
            r_d1[0].q     <= '0;
            r_d1[0].sat   <= (r1_num >= {r1_span, {QB{1'b0}}});
            r_d1[0].lower <= r1_lower;
            r_d1[0].frc   <= r1_frc;
        end
    end

    for (genvar gj = 0; gj < QB; gj++) begin : g_div1
        logic [NW-1:0]  w_sh;
        scs_pkg::t_nd1  n_d;
        always_comb begin
            w_sh = NW'(r_d1[gj].span) << (QB - 1 - gj);
            n_d  = r_d1[gj];
            if (!r_d1[gj].sat && r_d1[gj].rem >= w_sh) begin
                n_d.rem          = r_d1[gj].rem - w_sh;
                n_d.q[QB-1-gj]   = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv[scs_pkg::ST_SAT + 1 + gj]) begin
                r_d1[gj+1] <= n_d;
            end
        end
    end

    // Normalized value from the clamped quotient.
    logic [QB-1:0]        w_qc;
    logic signed [OW-1:0] n_v, r_v;

    always_comb begin
        if (r_d1[QB].sat || r_d1[QB].q > QB'(scs_pkg::FULL_SCALE)) begin
            w_qc = QB'(scs_pkg::FULL_SCALE);
        end else begin
            w_qc = r_d1[QB].q;
        end
        case (r_d1[QB].frc)
            scs_pkg::FRC_ZERO: n_v = '0;
            scs_pkg::FRC_NEG:  n_v = -OW'(scs_pkg::FULL_SCALE);
            default: begin
                if (r_d1[QB].lower) begin
                    n_v = OW'(w_qc) - OW'(scs_pkg::FULL_SCALE);
                end else begin
                    n_v = OW'(w_qc);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[scs_pkg::ST_NRM]) begin
            r_v <= n_v;
        end
    end

    // Deadzone setup and its divider.
    logic [DW-1:0] w_av;
    scs_pkg::t_nd2 r_d2 [0:QB];

    assign w_av = r_v[OW-1] ? DW'(-r_v) : DW'(r_v);

    always_ff @(posedge i_clk) begin
        if (w_adv[scs_pkg::ST_DZ]) begin
            r_d2[0].rem <= DNW'(w_av - r_cfg_dead) * DNW'(scs_pkg::FULL_SCALE);
            r_d2[0].den <= DW'(scs_pkg::FULL_SCALE) - r_cfg_dead;
            r_d2[0].q   <= '0;
            r_d2[0].byp <= (r_cfg_dead == '0);
            r_d2[0].inb <= (w_av <= r_cfg_dead);
            r_d2[0].neg <= r_v[OW-1];
            r_d2[0].v   <= r_v;
        end
    end

    for (genvar gk = 0; gk < QB; gk++) begin : g_div2
        logic [DNW-1:0] w_sh;
        scs_pkg::t_nd2  n_d;
        always_comb begin
            w_sh = DNW'(r_d2[gk].den) << (QB - 1 - gk);
            n_d  = r_d2[gk];
            if (r_d2[gk].rem >= w_sh) begin
                n_d.rem        = r_d2[gk].rem - w_sh;
                n_d.q[QB-1-gk] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv[scs_pkg::ST_DZ + 1 + gk]) begin
                r_d2[gk+1] <= n_d;
            end
        end
    end

    // Deadzoned value.
    logic signed [OW-1:0] n_x, r_x;

    always_comb begin
        if (r_d2[QB].byp) begin
            n_x = r_d2[QB].v;
        end else if (r_d2[QB].inb) begin
            n_x = '0;
        end else if (r_d2[QB].neg) begin
            n_x = -OW'(r_d2[QB].q);
        end else begin
            n_x = OW'(r_d2[QB].q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[scs_pkg::ST_X]) begin
            r_x <= n_x;
        end
    end

    // Expo: x*x/1000 via reciprocal multiply and one correction.
    logic [DW-1:0]        w_ax;
    logic [19:0]          r_sq_a, r_sqr_a;
    logic [30:0]          r_sqr_t;
    logic signed [OW-1:0] r_sq_x, r_sqr_x, r_sqc_x;
    logic [10:0]          w_sq_q0;
    logic [DW-1:0]        r_sqc_a1;

    assign w_ax    = r_x[OW-1] ? DW'(-r_x) : DW'(r_x);
    assign w_sq_q0 = 11'(r_sqr_t >> scs_pkg::SH_1000);

    always_ff @(posedge i_clk) begin
        if (w_adv[scs_pkg::ST_SQ]) begin
            r_sq_a <= 20'(w_ax) * 20'(w_ax);
            r_sq_x <= r_x;
        end
        if (w_adv[scs_pkg::ST_SQR]) begin
            r_sqr_t <= 31'(r_sq_a) * 31'(scs_pkg::RECIP_1000);
            r_sqr_a <= r_sq_a;
            r_sqr_x <= r_sq_x;
        end
        if (w_adv[scs_pkg::ST_SQC]) begin
            if (21'(w_sq_q0) * 21'(scs_pkg::FULL_SCALE) > 21'(r_sqr_a)) begin
                r_sqc_a1 <= DW'(w_sq_q0 - 11'd1);
            end else begin
                r_sqc_a1 <= DW'(w_sq_q0);
            end
            r_sqc_x <= r_sqr_x;
        end
    end

    // Expo: cube term (x*x/1000)*x/1000, truncated toward zero.
    logic [DW-1:0]        w_cx;
    logic [19:0]          r_cu_b, r_cur_b;
    logic [30:0]          r_cur_t;
    logic signed [OW-1:0] r_cu_x, r_cur_x, r_cuc_x, r_cuc_x3;
    logic [10:0]          w_cu_q0;
    logic [DW-1:0]        w_x3m;

    assign w_cx    = r_sqc_x[OW-1] ? DW'(-r_sqc_x) : DW'(r_sqc_x);
    assign w_cu_q0 = 11'(r_cur_t >> scs_pkg::SH_1000);

    always_comb begin
        if (21'(w_cu_q0) * 21'(scs_pkg::FULL_SCALE) > 21'(r_cur_b)) begin
            w_x3m = DW'(w_cu_q0 - 11'd1);
        end else begin
            w_x3m = DW'(w_cu_q0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[scs_pkg::ST_CU]) begin
            r_cu_b <= 20'(r_sqc_a1) * 20'(w_cx);
            r_cu_x <= r_sqc_x;
        end
        if (w_adv[scs_pkg::ST_CUR]) begin
            r_cur_t <= 31'(r_cu_b) * 31'(scs_pkg::RECIP_1000);
            r_cur_b <= r_cu_b;
            r_cur_x <= r_cu_x;
        end
        if (w_adv[scs_pkg::ST_CUC]) begin
            r_cuc_x3 <= r_cur_x[OW-1] ? -OW'(w_x3m) : OW'(w_x3m);
            r_cuc_x  <= r_cur_x;
        end
    end

    // Blend: ((100-k)*x + k*x3) / 100, signed and truncated toward zero.
    logic signed [7:0]    w_wl, w_k;
    logic signed [18:0]   r_mix_p1, r_mix_p2;
    logic signed [19:0]   w_sum;
    logic signed [OW-1:0] r_mix_x, r_sum_x, r_dvr_x;
    logic [17:0]          r_sum_m, r_dvr_m;
    logic                 r_sum_neg, r_dvr_neg;
    logic [35:0]          r_dvr_t;

    assign w_k   = $signed({1'b0, r_cfg_expo});
    assign w_wl  = 8'(scs_pkg::PERCENT) - w_k;
    assign w_sum = 20'(r_mix_p1) + 20'(r_mix_p2);

    always_ff @(posedge i_clk) begin
        if (w_adv[scs_pkg::ST_MIX]) begin
            r_mix_p1 <= 19'(w_wl) * 19'(r_cuc_x);
            r_mix_p2 <= 19'(w_k) * 19'(r_cuc_x3);
            r_mix_x  <= r_cuc_x;
        end
        if (w_adv[scs_pkg::ST_SUM]) begin
            r_sum_m   <= w_sum[19] ? 18'(-w_sum) : 18'(w_sum);
            r_sum_neg <= w_sum[19];
            r_sum_x   <= r_mix_x;
        end
        if (w_adv[scs_pkg::ST_DVR]) begin
            r_dvr_t   <= 36'(r_sum_m) * 36'(scs_pkg::RECIP_100);
            r_dvr_m   <= r_sum_m;
            r_dvr_neg <= r_sum_neg;
            r_dvr_x   <= r_sum_x;
        end
    end

    // Final quotient, clamp and output register.
    logic [11:0]          w_oq0, w_oq;
    logic [OW-1:0]        w_oqs;
    logic signed [OW-1:0] n_out, r_out;

    always_comb begin
        w_oq0 = 12'(r_dvr_t >> scs_pkg::SH_100);
        if (18'(w_oq0) * 18'(scs_pkg::PERCENT) > r_dvr_m) begin
            w_oq = w_oq0 - 12'd1;
        end else begin
            w_oq = w_oq0;
        end
        if (w_oq > 12'(scs_pkg::FULL_SCALE)) begin
            w_oqs = OW'(scs_pkg::FULL_SCALE);
        end else begin
            w_oqs = OW'(w_oq);
        end
        if (r_cfg_expo == '0) begin
            n_out = r_dvr_x;
        end else if (r_dvr_neg) begin
            n_out = -w_oqs;
        end else begin
            n_out = w_oqs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[scs_pkg::ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_shp.valid        = r_vld[scs_pkg::ST_OUT];
    assign o_shp.shaped_value = r_out;

`ifndef ASSERT_OFF
    // A result word never leaves the full-scale range.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_shp.valid |-> (r_out >= -OW'(scs_pkg::FULL_SCALE) &&
                         r_out <= OW'(scs_pkg::FULL_SCALE)))
        else $error("shaped value out of range");

    // The deadzone quotient stays within full scale when it is used.
    a_dz_quot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[scs_pkg::ST_X - 1] && !r_d2[QB].byp && !r_d2[QB].inb) |->
        (r_d2[QB].q <= QB'(scs_pkg::FULL_SCALE)))
        else $error("deadzone quotient above full scale");

    // An accepted input word lands in the first stage.
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_raw.valid && i_raw.ready) |=> r_vld[scs_pkg::ST_IN])
        else $error("accepted word not captured");

    // A stage that cannot advance keeps its word.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[scs_pkg::ST_NRM] && !w_adv[scs_pkg::ST_NRM + 1]) |=>
        (r_vld[scs_pkg::ST_NRM] && $stable(r_v)))
        else $error("stalled stage lost its word");
`endif

endmodule

// File: test/scs_checker.sv
// Checker for the stick channel shaping block: watches both channels, predicts
// each shaped word from the sampled raw word and the register writes, compares.
// Depends on scs_pkg and the channel interfaces in scs_chan_if.sv.
`timescale 1ns / 1ps

module scs_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    scs_raw_if                                  i_raw,
    scs_shp_if                                  i_shp,
    input  logic                                i_cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [scs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_errors,
    output int                                  o_shaped_count,
    output int                                  o_pending
);

    logic [15:0] cal_lo, cal_mid, cal_hi;
    logic [9:0]  dz_width;
    logic [6:0]  expo_pct;
    logic signed [scs_pkg::OUT_W-1:0] shaped_q[$];

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Normalize, deadzone and expo, all in 32-bit signed arithmetic.
    function automatic logic signed [scs_pkg::OUT_W-1:0] shape_word(logic [15:0] raw);
        logic [15:0] span;
        int v;
        int dz;
        int x3;
        int k;
        int fs;
        int pc;
        fs = scs_pkg::FULL_SCALE;
        pc = scs_pkg::PERCENT;
        if (cal_hi == cal_lo) begin
            v = 0;
        end else if (raw <= cal_mid) begin
            span = cal_mid - cal_lo;
            if (span == 0) v = 0;
            else v = clamp(-fs + (int'(raw) - int'(cal_lo)) * fs / int'(span), -fs, 0);
        end else begin
            span = cal_hi - cal_mid;
            if (span == 0) v = 0;
            else v = clamp((int'(raw) - int'(cal_mid)) * fs / int'(span), 0, fs);
        end
        dz = int'(dz_width);
        if (dz > 0) begin
            if (v >= -dz && v <= dz) v = 0;
            else if (v > dz) v = clamp((v - dz) * fs / (fs - dz), -fs, fs);
            else v = clamp((v + dz) * fs / (fs - dz), -fs, fs);
        end
        k = int'(expo_pct);
        if (k != 0) begin
            x3 = v * v / fs * v / fs;
            v = clamp(((pc - k) * v + k * x3) / pc, -fs, fs);
        end
        return v[scs_pkg::OUT_W-1:0];
    endfunction

    task automatic report(string what, logic signed [scs_pkg::OUT_W-1:0] got,
                          logic signed [scs_pkg::OUT_W-1:0] want);
        $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_shaped_count = 0;
        o_pending = 0;
    end

    // Registers update after the prediction of a word accepted at the same edge.
    always @(posedge i_clk) begin
        logic signed [scs_pkg::OUT_W-1:0] want;
        if (!i_rst_n) begin
            cal_lo = 16'd0; cal_mid = 16'd32768; cal_hi = 16'd65535;
            dz_width = '0; expo_pct = '0;
            shaped_q.delete();
        end else begin
            if (i_raw.valid && i_raw.ready) shaped_q.push_back(shape_word(i_raw.raw_sample));
            if (i_shp.valid && i_shp.ready) begin
                o_shaped_count++;
                if (shaped_q.size() == 0) begin
                    report("unexpected word", i_shp.shaped_value, '0);
                end else begin
                    want = shaped_q.pop_front();
                    if (i_shp.shaped_value !== want)
                        report("shaped_value", i_shp.shaped_value, want);
                end
            end
            if (i_cfg_we) begin
                case (scs_pkg::t_cfg_idx'(i_cfg_idx))
                    scs_pkg::CFG_MIN:    cal_lo = i_cfg_data;
                    scs_pkg::CFG_CENTER: cal_mid = i_cfg_data;
                    scs_pkg::CFG_MAX:    cal_hi = i_cfg_data;
                    scs_pkg::CFG_DEAD:   dz_width = i_cfg_data[9:0];
                    scs_pkg::CFG_EXPO:   expo_pct = i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
        o_pending = shaped_q.size();
    end
endmodule

// File: test/tb_top.sv
// Testbench top for stick_channel_shaping: clock, reset, register phases,
// directed and random raw words, bursty sender, stalling receiver, verdict.
// Depends on scs_pkg, scs_chan_if.sv, the block and scs_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [scs_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [scs_pkg::CFG_DATA_W-1:0] i_cfg_data;
    int errors, shaped_count, pending;
    int idle_cycles;
    int phase_count;
    bit long_hold;

    scs_raw_if raw_ch();
    scs_shp_if shp_ch();

    stick_channel_shaping uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_raw(raw_ch), .o_shp(shp_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    scs_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_raw(raw_ch), .i_shp(shp_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_shaped_count(shaped_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    // Receiver stall pattern, with one long hold-off on request.
    initial begin
        int mode;
        shp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                shp_ch.ready <= 1'b0;
                repeat (120) @(negedge i_clk);
                long_hold = 1'b0;
            end
            mode = (shaped_count / 200) % 3;
            if (mode == 0) shp_ch.ready <= 1'b1;
            else if (mode == 1) shp_ch.ready <= ($urandom_range(0, 3) != 0);
            else shp_ch.ready <= ($urandom_range(0, 1) != 0);
        end
    end

    // Watchdog on cycles without any accepted word or register write.
    always @(posedge i_clk) begin
        if ((raw_ch.valid && raw_ch.ready) || (shp_ch.valid && shp_ch.ready)
            || !i_rst_n || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout with %0d words pending", pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drive one register write; the caller drops the write enable afterwards.
    task automatic write_reg(scs_pkg::t_cfg_idx idx, logic [scs_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic set_shaping(logic [15:0] lo, logic [15:0] mid, logic [15:0] hi,
                               logic [9:0] dz, logic [6:0] ex);
        write_reg(scs_pkg::CFG_MIN, lo);
        write_reg(scs_pkg::CFG_CENTER, mid);
        write_reg(scs_pkg::CFG_MAX, hi);
        write_reg(scs_pkg::CFG_DEAD, 16'(dz));
        write_reg(scs_pkg::CFG_EXPO, 16'(ex));
        i_cfg_we <= 1'b0;
        phase_count++;
    endtask

    // Offer one word and hold it until accepted; burst gaps come from the caller.
    task automatic send_raw(logic [15:0] raw);
        raw_ch.valid <= 1'b1;
        raw_ch.raw_sample <= raw;
        @(posedge i_clk);
        while (!raw_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_burst(int n);
        int left;
        int gap;
        left = n;
        while (left > 0) begin
            int burst;
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && left > 0; i++) begin
                case ($urandom_range(0, 7))
                    0: send_raw(16'h0000);
                    1: send_raw(16'hFFFF);
                    2: send_raw(16'(32768 + $urandom_range(0, 64) - 32));
                    default: send_raw(16'($urandom_range(0, 65535)));
                endcase
                left--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                raw_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        raw_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [15:0] a, b, c;
        logic [15:0] edges[] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h8001,
                                 16'hAAAA, 16'h5555, 16'hFFFE, 16'hFFFF, 16'd1000};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        raw_ch.valid = 1'b0;
        raw_ch.raw_sample = '0;
        idle_cycles = 0;
        phase_count = 0;
        long_hold = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words at reset calibration: full range, no deadzone, linear.
        foreach (edges[i]) send_raw(edges[i]);
        raw_ch.valid <= 1'b0;
        drain();
        // Narrow calibration with samples outside it, wide deadzone, full expo.
        set_shaping(16'd1000, 16'd1500, 16'd2000, 10'd999, 7'd100);
        foreach (edges[i]) send_raw(edges[i]);
        send_raw(16'd1999); send_raw(16'd1001);
        raw_ch.valid <= 1'b0;
        drain();
        // Degenerate spans and expo beyond 100.
        set_shaping(16'd500, 16'd500, 16'd500, 10'd0, 7'd127);
        send_raw(16'd500); send_raw(16'd0); send_raw(16'hFFFF);
        raw_ch.valid <= 1'b0;
        drain();
        set_shaping(16'd40000, 16'd100, 16'd9000, 10'd1023, 7'd50);
        send_raw(16'd50); send_raw(16'd100); send_raw(16'd5000);
        raw_ch.valid <= 1'b0;
        drain();

        // Pressure: long receiver hold-off while words keep coming.
        long_hold = 1'b1;
        set_shaping(16'd0, 16'd32768, 16'd65535, 10'd100, 7'd30);
        send_burst(150);
        drain();

        // Random phases: ordered calibrations mostly, scrambled ones sometimes.
        for (int p = 0; p < 10; p++) begin
            a = 16'($urandom_range(0, 20000));
            c = 16'($urandom_range(45000, 65535));
            b = 16'($urandom_range(a, c));
            if (p % 4 == 3) begin
                a = 16'($urandom); b = 16'($urandom); c = 16'($urandom);
            end
            set_shaping(a, b, c, (p % 5 == 0) ? 10'd0 : 10'($urandom_range(0, 1023)),
                        (p % 3 == 0) ? 7'd0 : 7'($urandom_range(0, 127)));
            send_burst(95);
            drain();
        end

        $display("Covered %0d register settings and %0d shaped words, with degenerate",
                 phase_count, shaped_count);
        $display("calibrations, deadzones to full width, expo to 127 and a long stall.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
